FILE: design/pdta_pkg.sv
// Shared types and codes for the process dispatcher with time accounting.
// No dependencies.
package pdta_pkg;

    localparam int MAX_ENTRIES_DEF = 32;
    localparam int FIFO_DEPTH      = 32;
    localparam int FIFO_AW         = 5;
    localparam int FIFO_CW         = 6;

    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_BLOCK   = 3'd1;
    localparam logic [2:0] OP_WAKE    = 3'd2;
    localparam logic [2:0] OP_TIMEOUT = 3'd3;
    localparam logic [2:0] OP_EXIT    = 3'd4;
    localparam logic [2:0] OP_REPORT  = 3'd5;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_EXITED  = 2'd3;

    typedef struct packed {
        logic [7:0]  pid;
        logic [1:0]  status;
        logic [31:0] run;
        logic [31:0] rdy;
        logic [31:0] blk;
    } t_entry;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

FILE: design/pdta_cell.sv
// One process-table slot of the rotating ring.
// Depends on pdta_pkg.
module pdta_cell
    import pdta_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;

    // Reset loads the idle-process image; only slot 0 of it is ever read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '{pid: 8'd0, status: ST_RUNNING, run: 32'd0, rdy: 32'd0, blk: 32'd0};
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: design/process_dispatcher_time_accounting.sv
// Process dispatcher with per-process time accounting, table held in a ring of cells.
// Events pass the ring for charge/lookup, popped-pid lookup and status write, in that order.
// Report: the accepted transfer enters the report state, and each entry is then registered onto the output;
// one result per cycle while the output is not stalled.
// Rate is set by the ring: every entry passes the head cell once per pass.
// Synchronous active-low reset: idle process only, running, empty ready queue.
module process_dispatcher_time_accounting
    import pdta_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [39:0]   s_axis_tdata,  // event_time[31:0], pid[39:32]
    input  logic [2:0]    s_axis_tuser,  // op[2:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,  // proc_id, run_total, ready_total, blocked_total
    output logic          m_axis_tlast   // last
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_ENTRIES - 1);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_ENTRIES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PA   = 3'd1;
    localparam logic [2:0] S_PB   = 3'd2;
    localparam logic [2:0] S_PC   = 3'd3;
    localparam logic [2:0] S_REP  = 3'd4;

    logic [2:0]    r_state;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic [2:0]    r_op;
    logic [7:0]    r_pid;
    logic [31:0]   r_prev;
    logic [31:0]   r_delta;
    logic          r_found_a;
    logic [CW-1:0] r_match_a;
    logic          r_run_found;
    logic [CW-1:0] r_run_idx;
    logic [7:0]    r_run_pid;
    logic [1:0]    r_st0;
    logic          r_found_p;
    logic [CW-1:0] r_match_p;

    logic [7:0]          r_fifo [FIFO_DEPTH];
    logic [7:0]          r_fifo_rd;
    logic [FIFO_AW-1:0]  r_fhead;
    logic [FIFO_CW-1:0]  r_fcnt;

    logic          r_ov;
    logic [103:0]  r_odata;
    logic          r_olast;

    t_entry cell_q [MAX_ENTRIES];
    t_entry head_n;
    t_entry head;
    logic   shift;
    logic   step;
    logic   in_xfer;

    // dispatch decisions
    logic          create_ok;
    logic [7:0]    pop_pid;
    logic [CW-1:0] start2;
    logic          w1v, w2v, w3v;
    logic [CW-1:0] w1i, w2i, w3i;
    logic [1:0]    w1s, w2s, w3s;
    logic          push_en;
    logic [7:0]    push_val;
    logic          pop_en;
    logic [CW-1:0] pmatch;
    logic          wake_direct;

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_ring
            if (g == MAX_ENTRIES - 1) begin : g_tail
                pdta_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (shift),
                    .i_entry (head_n),
                    .o_entry (cell_q[g])
                );
            end else begin : g_body
                pdta_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (shift),
                    .i_entry (cell_q[g+1]),
                    .o_entry (cell_q[g])
                );
            end
        end
    endgenerate

    assign head          = cell_q[0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign step          = !r_ov || m_axis_tready;
    assign shift         = (r_state == S_PA) || (r_state == S_PB) || (r_state == S_PC) ||
                           ((r_state == S_REP) && step);

    always_comb begin
        create_ok   = (r_count < MAX_CNT);
        wake_direct = r_found_a && (r_fcnt == '0) && (r_st0 == ST_RUNNING);
        pop_pid     = r_fifo_rd;
        start2      = CW'(1);
        w1v = 1'b0; w1i = '0; w1s = ST_READY;
        w2v = 1'b0; w2i = '0; w2s = ST_READY;
        w3v = 1'b0; w3i = '0; w3s = ST_READY;
        push_en  = 1'b0;
        push_val = r_pid;
        pop_en   = 1'b0;
        pmatch   = r_found_p ? r_match_p : '0;
        unique case (r_op)
            OP_CREATE: begin
                pop_pid = r_pid;
                start2  = '0;
                push_en = create_ok;
                if (create_ok && (r_fcnt == '0) && (r_st0 == ST_RUNNING)) begin
                    pop_en = 1'b1;
                    w2v = 1'b1; w2i = '0; w2s = ST_READY;
                    w3v = 1'b1; w3i = r_found_p ? r_match_p : r_count; w3s = ST_RUNNING;
                end
            end
            OP_BLOCK, OP_EXIT: begin
                w1v = r_found_a; w1i = r_match_a;
                w1s = (r_op == OP_BLOCK) ? ST_BLOCKED : ST_EXITED;
                pop_en = (r_fcnt != '0);
                w2v = 1'b1; w2i = pop_en ? pmatch : '0; w2s = ST_RUNNING;
            end
            OP_WAKE: begin
                w1v = r_found_a; w1i = r_match_a; w1s = ST_READY;
                push_en = r_found_a && !wake_direct;
                w2v = wake_direct; w2i = '0; w2s = ST_READY;
                w3v = wake_direct; w3i = r_match_a; w3s = ST_RUNNING;
            end
            OP_TIMEOUT: begin
                start2   = '0;
                pop_pid  = (r_fcnt == '0) ? r_run_pid : r_fifo_rd;
                push_en  = r_run_found;
                push_val = r_run_pid;
                pop_en   = r_run_found;
                if (r_run_found) begin
                    w1v = 1'b1; w1i = r_run_idx; w1s = ST_READY;
                    w2v = 1'b1; w2i = pmatch; w2s = ST_RUNNING;
                end else begin
                    w1v = 1'b1; w1i = '0; w1s = ST_RUNNING;
                end
            end
            default: begin
            end
        endcase
    end

    // head cell update, then back into the tail
    always_comb begin
        head_n = head;
        if (r_state == S_PA && r_idx < r_count) begin
            unique case (head.status)
                ST_READY:   head_n.rdy = sat_add(head.rdy, r_delta);
                ST_RUNNING: head_n.run = sat_add(head.run, r_delta);
                ST_BLOCKED: head_n.blk = sat_add(head.blk, r_delta);
                default:    head_n = head;
            endcase
        end else if (r_state == S_PC) begin
            if (r_op == OP_CREATE && create_ok && r_idx == r_count) begin
                head_n = '{pid: r_pid, status: ST_READY, run: 32'd0, rdy: 32'd0, blk: 32'd0};
            end
            if (w1v && r_idx == w1i) head_n.status = w1s;
            if (w2v && r_idx == w2i) head_n.status = w2s;
            if (w3v && r_idx == w3i) head_n.status = w3s;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fifo_rd <= r_fifo[r_fhead];
        if (r_state == S_PC && r_idx == LAST_IDX && push_en &&
            r_fcnt < FIFO_CW'(FIFO_DEPTH)) begin
            r_fifo[r_fhead + r_fcnt[FIFO_AW-1:0]] <= push_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_count <= CW'(1);
            r_prev  <= 32'd0;
            r_fhead <= '0;
            r_fcnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && m_axis_tready && !(r_state == S_REP && r_idx < r_count)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_op        <= s_axis_tuser;
                        r_pid       <= s_axis_tdata[39:32];
                        r_found_a   <= 1'b0;
                        r_run_found <= 1'b0;
                        r_found_p   <= 1'b0;
                        r_idx       <= '0;
                        if (s_axis_tuser == OP_REPORT) begin
                            r_state <= S_REP;
                        end else if (s_axis_tuser < OP_REPORT || s_axis_tuser == OP_EXIT) begin
                            r_state <= S_PA;
                            r_prev  <= s_axis_tdata[31:0];
                            r_delta <= (s_axis_tdata[31:0] >= r_prev) ?
                                       s_axis_tdata[31:0] - r_prev : 32'd0;
                        end
                    end
                end
                S_PA: begin
                    if (r_idx == '0) r_st0 <= head.status;
                    if (r_idx != '0 && r_idx < r_count) begin
                        if (!r_found_a && head.pid == r_pid) begin
                            r_found_a <= 1'b1;
                            r_match_a <= r_idx;
                        end
                        if (!r_run_found && head.status == ST_RUNNING) begin
                            r_run_found <= 1'b1;
                            r_run_idx   <= r_idx;
                            r_run_pid   <= head.pid;
                        end
                    end
                    r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + CW'(1);
                    if (r_idx == LAST_IDX) r_state <= S_PB;
                end
                S_PB: begin
                    if (!r_found_p && r_idx >= start2 && r_idx < r_count &&
                        head.pid == pop_pid) begin
                        r_found_p <= 1'b1;
                        r_match_p <= r_idx;
                    end
                    r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + CW'(1);
                    if (r_idx == LAST_IDX) r_state <= S_PC;
                end
                S_PC: begin
                    r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + CW'(1);
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                        if (r_op == OP_CREATE && create_ok) r_count <= r_count + CW'(1);
                        // push lands before the pop
                        if (pop_en) r_fhead <= r_fhead + FIFO_AW'(1);
                        if (push_en && r_fcnt < FIFO_CW'(FIFO_DEPTH)) begin
                            if (!pop_en) r_fcnt <= r_fcnt + FIFO_CW'(1);
                        end else if (pop_en) begin
                            r_fcnt <= r_fcnt - FIFO_CW'(1);
                        end
                    end
                end
                S_REP: begin
                    if (step) begin
                        if (r_idx < r_count) begin
                            r_ov    <= 1'b1;
                            r_odata <= {head.blk, head.rdy, head.run, head.pid};
                            r_olast <= (r_idx + CW'(1) == r_count);
                        end
                        r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + CW'(1);
                        if (r_idx == LAST_IDX) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= FIFO_CW'(FIFO_DEPTH))
        else $error("ready queue count out of range");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CW'(1) && r_count <= MAX_CNT)
        else $error("table count out of range");
    a_event_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tuser <= OP_REPORT) |=> r_state != S_IDLE)
        else $error("accepted event not started");
    a_idle_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_idx == '0)
        else $error("ring misaligned at idle");
`endif

endmodule
